>>> rtl/core/edrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edrs_pkg
// Types and constants shared by the c-scan disk request scheduler.
// ----------------------------------------------------------------------------
package edrs_pkg;

	localparam int TableDepthDefault = 32;

	localparam int          SectorsPerTrack = 9;
	localparam int          TracksPerCyl    = 2;
	localparam int          CylsPerDisk     = 40;
	localparam logic [15:0] MAX_BYTES   = 16'd1024;
	localparam logic [15:0] BLOCK_LIMIT =
		16'(CylsPerDisk * TracksPerCyl * SectorsPerTrack / TracksPerCyl);
	localparam logic [3:0]  SECTORS     = 4'(SectorsPerTrack);
	// reciprocal of 9, exact for every 16-bit dividend
	localparam logic [18:0] DIV9_MUL    = 19'd466034;
	localparam int          Div9Shift   = 22;

	localparam logic [7:0] OP_READ  = 8'd1;
	localparam logic [7:0] OP_WRITE = 8'd2;
	localparam logic [7:0] OP_IDLE  = 8'd0;

	typedef enum logic [1:0] {
		ST_SERVED  = 2'd0,
		ST_IDLE    = 2'd1,
		ST_ACCEPT  = 2'd2,
		ST_DROPPED = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DIV,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [7:0]  op;
		logic [15:0] id;
		logic [15:0] blk;
		logic [15:0] size;
		logic [31:0] addr;
		logic [15:0] age;
	} entry_t;

endpackage
`default_nettype wire

>>> rtl/core/edrs_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edrs_cell
// One table slot; takes its neighbor's contents while the table rotates.
// ----------------------------------------------------------------------------
module edrs_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            shift,
	input  wire logic            nb_valid,
	input  wire edrs_pkg::entry_t nb_entry,
	input  wire logic            wr,
	input  wire edrs_pkg::entry_t wr_entry,
	input  wire logic            clr,
	output logic                 valid_q,
	output edrs_pkg::entry_t     entry_q
);
	import edrs_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= nb_valid;
		end else if (wr) begin
			valid_q <= 1'b1;
		end else if (clr) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			entry_q <= nb_entry;
		end else if (wr) begin
			entry_q <= wr_entry;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/elevator_disk_request_scheduler_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// elevator_disk_request_scheduler_core
// C-SCAN scheduler: a rotating row of slot cells, scanned one slot a cycle.
// ----------------------------------------------------------------------------
// channel   signals                                   handshake
// request   kind op_code request_id req_block ...     start & !busy
// result    status out_request_id ... error_flags     strobe, one cycle
//
// a submit leaves busy low, so submits may follow each cycle
// a serve keeps busy high while the table rotates once through slot 0 past
// the compare unit, then through a divide-by-9 state and an output state
// the result beat appears in the cycle after the last working cycle
// reset clears all slot valid bits, the arrival count and the last block
// the receiver cannot stall; busy is the only back pressure
module elevator_disk_request_scheduler_core #(
	parameter int TABLE_DEPTH = edrs_pkg::TableDepthDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        kind,
	input  wire logic [7:0]  op_code,
	input  wire logic [15:0] request_id,
	input  wire logic [15:0] req_block,
	input  wire logic signed [15:0] req_size,
	input  wire logic [31:0] data_address,
	output logic             strobe,
	output logic [1:0]       status,
	output logic [15:0]      out_request_id,
	output logic [7:0]       out_op_code,
	output logic [15:0]      out_block,
	output logic signed [15:0] out_size,
	output logic [31:0]      out_address,
	output logic [12:0]      cylinder,
	output logic             track,
	output logic [3:0]       sector,
	output logic [3:0]       error_flags
);
	import edrs_pkg::*;

	localparam int IW = $clog2(TABLE_DEPTH);

	state_t state_q, state_d;

	logic   [TABLE_DEPTH-1:0] valid_w;
	entry_t                   entry_w [TABLE_DEPTH];
	logic   [TABLE_DEPTH-1:0] wr_w, clr_w;
	entry_t                   wr_entry;
	logic                     shift;

	logic [15:0]   counter_q, last_q;
	logic [IW-1:0] cnt_q, best_idx_q;
	logic          found_q;
	logic [32:0]   best_key_q;
	entry_t        best_q;
	logic [12:0]   quo_q;

	logic          accept, submit, serve;
	logic          full;
	logic [IW-1:0] free_idx;
	logic [15:0]   age_gap, bm1;
	logic [32:0]   key;
	logic          take;
	logic [34:0]   prod;
	logic [15:0]   rem16;
	logic [3:0]    rem;
	logic [4:0]    sec2;
	logic          neg, pow2;
	logic [3:0]    flags;

	assign accept = start && !busy;
	assign submit = accept && !kind;
	assign serve  = accept && kind;
	assign shift  = (state_q == S_SCAN);

	// lowest free slot
	always_comb begin
		full     = 1'b1;
		free_idx = '0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (!valid_w[i]) begin
				full     = 1'b0;
				free_idx = IW'(i);
			end
		end
	end

	always_comb begin
		wr_entry.op   = op_code;
		wr_entry.id   = request_id;
		wr_entry.blk  = req_block;
		wr_entry.size = req_size;
		wr_entry.addr = data_address;
		wr_entry.age  = counter_q;
	end

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		assign wr_w[g]  = submit && (op_code != OP_IDLE) && !full && (free_idx == IW'(g));
		assign clr_w[g] = (state_q == S_DIV) && found_q && (best_idx_q == IW'(g));
		edrs_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift    (shift),
			.nb_valid (valid_w[(g + 1) % TABLE_DEPTH]),
			.nb_entry (entry_w[(g + 1) % TABLE_DEPTH]),
			.wr       (wr_w[g]),
			.wr_entry (wr_entry),
			.clr      (clr_w[g]),
			.valid_q  (valid_w[g]),
			.entry_q  (entry_w[g])
		);
	end

	// key: entries below the head sort last, then block, then oldest
	assign age_gap = counter_q - entry_w[0].age;
	assign key     = {entry_w[0].blk < last_q, entry_w[0].blk, ~age_gap};
	assign take    = valid_w[0] && (!found_q || key < best_key_q);

	assign bm1  = best_q.blk - 16'd1;
	assign prod = 35'(bm1) * 35'(DIV9_MUL);
	assign rem16 = bm1 - {quo_q, 3'b000} - 16'(quo_q);
	assign rem   = rem16[3:0];
	assign sec2  = {rem, 1'b0};
	assign neg   = best_q.size[15];
	assign pow2  = (best_q.blk & bm1) == 16'd0;
	assign flags = {(neg && pow2) || (!neg && best_q.size > MAX_BYTES),
		(best_q.blk < 16'd1) || (best_q.blk > BLOCK_LIMIT),
		best_q.id == 16'd0,
		(best_q.op != OP_READ) && (best_q.op != OP_WRITE)};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (serve) state_d = S_SCAN;
			S_SCAN: if (cnt_q == IW'(TABLE_DEPTH - 1)) state_d = S_DIV;
			S_DIV:  state_d = S_FIN;
			S_FIN:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q != S_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			counter_q <= '0;
			last_q    <= '0;
			cnt_q     <= '0;
			found_q   <= 1'b0;
			strobe    <= 1'b0;
		end else begin
			state_q <= state_d;
			strobe  <= 1'b0;
			if (submit) begin
				strobe <= 1'b1;
				if (op_code != OP_IDLE && !full) begin
					counter_q <= counter_q + 16'd1;
				end
			end
			if (serve) begin
				cnt_q   <= '0;
				found_q <= 1'b0;
			end
			if (state_q == S_SCAN) begin
				cnt_q <= cnt_q + IW'(1);
				if (take) found_q <= 1'b1;
			end
			if (state_q == S_FIN) begin
				strobe <= 1'b1;
				if (found_q) last_q <= best_q.blk;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SCAN && take) begin
			best_key_q <= key;
			best_q     <= entry_w[0];
			best_idx_q <= cnt_q;
		end
		if (state_q == S_DIV) begin
			quo_q <= prod[Div9Shift +: 13];
		end
		if (submit) begin
			if (op_code == OP_IDLE) status <= ST_IDLE;
			else if (full)          status <= ST_DROPPED;
			else                    status <= ST_ACCEPT;
			out_request_id <= '0;
			out_op_code    <= '0;
			out_block      <= '0;
			out_size       <= '0;
			out_address    <= '0;
			cylinder       <= '0;
			track          <= 1'b0;
			sector         <= '0;
			error_flags    <= '0;
		end else if (state_q == S_FIN) begin
			if (found_q) begin
				status         <= ST_SERVED;
				out_request_id <= best_q.id;
				out_op_code    <= best_q.op;
				out_block      <= best_q.blk;
				out_size       <= best_q.size;
				out_address    <= best_q.addr;
				error_flags    <= flags;
				if (best_q.blk != 16'd0) begin
					cylinder <= quo_q;
					track    <= rem >= 4'd5;
					sector   <= (sec2 > {1'b0, SECTORS}) ?
						4'(sec2 - {1'b0, SECTORS}) : sec2[3:0];
				end else begin
					cylinder <= '0;
					track    <= 1'b0;
					sector   <= '0;
				end
			end else begin
				status         <= ST_IDLE;
				out_request_id <= '0;
				out_op_code    <= '0;
				out_block      <= '0;
				out_size       <= '0;
				out_address    <= '0;
				cylinder       <= '0;
				track          <= 1'b0;
				sector         <= '0;
				error_flags    <= '0;
			end
		end
	end

endmodule
`default_nettype wire
